// ===== design/date_time_duration_adder_defines.svh =====
// assertion macros shared by the checker
`ifndef DATE_TIME_DURATION_ADDER_DEFINES_SVH
`define DATE_TIME_DURATION_ADDER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DTDA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DTDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dtda_pkg.sv =====
package dtda_pkg;

    // field widths of the working values
    localparam int YR_W   = 16;
    localparam int DAY_W  = 10;
    localparam int MI_W   = 4;
    localparam int Y400_W = 9;

    localparam logic [YR_W-1:0]   YEAR_MAX  = 16'd9999;
    localparam logic [15:0]       CYCLE_LEN = 16'd400;
    localparam logic [MI_W-1:0]   LAST_MI   = 4'd11;
    localparam logic [Y400_W-1:0] LAST_Y400 = 9'd399;

    // state handed from cell to cell
    typedef struct packed {
        logic [DAY_W-1:0]  days;
        logic [MI_W-1:0]   mi;
        logic [YR_W-1:0]   yr;
        logic [Y400_W-1:0] y400;
        logic [5:0]        minute;
        logic [4:0]        hour;
    } cell_data_t;

    // leap year from the year modulo 400
    function automatic logic is_leap(input logic [Y400_W-1:0] y400);
        logic century;
        century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
        return (y400[1:0] == 2'd0) && !century;
    endfunction

    // month length for a month index 0..11
    function automatic logic [4:0] month_days(input logic [MI_W-1:0] mi,
                                              input logic leap);
        logic [4:0] len;
        unique case (mi) inside
            4'd1:                    len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== design/dtda_prep.sv =====
module dtda_prep #(
    parameter int MAX_ADD_DAYS = 366
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    in_valid,
    input  logic [13:0]             base_year,
    input  logic [3:0]              base_month,
    input  logic [4:0]              base_day,
    input  logic [4:0]              base_hour,
    input  logic [5:0]              base_minute,
    input  logic [13:0]             add_years,
    input  logic [3:0]              add_months,
    input  logic [8:0]              add_days,
    input  logic [4:0]              add_hours,
    input  logic [5:0]              add_minutes,
    output logic                    out_valid,
    output dtda_pkg::cell_data_t    out_data
);

    localparam int ADD_CLAMP = (MAX_ADD_DAYS > 511) ? 511 : MAX_ADD_DAYS;
    localparam logic [8:0] ADD_CLAMP_V = 9'(ADD_CLAMP);

    logic [3:0]  bmo_c;
    logic [4:0]  bd_c;
    logic [8:0]  ad_c;
    logic [6:0]  mins;
    logic [5:0]  minute_s;
    logic [1:0]  hr_carry;
    logic [6:0]  hrs;
    logic [4:0]  hour_s;
    logic [1:0]  day_carry;
    logic [9:0]  days_s;
    logic [4:0]  mi_sum;
    logic [3:0]  mi_s;
    logic [1:0]  yr_carry;
    logic [15:0] yr_s;

    dtda_pkg::cell_data_t s1_reg, s1_next;
    logic                 s1_valid_reg;
    dtda_pkg::cell_data_t s2_reg, s2_next;
    logic                 s2_valid_reg;
    logic [15:0]          rem;

    // clamp the inputs and fold minutes, hours and months
    always_comb
    begin
        bmo_c = (base_month == 4'd0) ? 4'd1 : ((base_month > 4'd12) ? 4'd12 : base_month);
        bd_c  = (base_day == 5'd0) ? 5'd1 : base_day;
        ad_c  = (add_days > ADD_CLAMP_V) ? ADD_CLAMP_V : add_days;

        mins = 7'(base_minute) + 7'(add_minutes);
        if (mins >= 7'd120)
        begin
            minute_s = 6'(mins - 7'd120);
            hr_carry = 2'd2;
        end
        else if (mins >= 7'd60)
        begin
            minute_s = 6'(mins - 7'd60);
            hr_carry = 2'd1;
        end
        else
        begin
            minute_s = 6'(mins);
            hr_carry = 2'd0;
        end

        hrs = 7'(base_hour) + 7'(add_hours) + 7'(hr_carry);
        if (hrs >= 7'd48)
        begin
            hour_s    = 5'(hrs - 7'd48);
            day_carry = 2'd2;
        end
        else if (hrs >= 7'd24)
        begin
            hour_s    = 5'(hrs - 7'd24);
            day_carry = 2'd1;
        end
        else
        begin
            hour_s    = 5'(hrs);
            day_carry = 2'd0;
        end
        days_s = 10'(bd_c) + 10'(ad_c) + 10'(day_carry);

        mi_sum = 5'(bmo_c - 4'd1) + 5'(add_months);
        if (mi_sum >= 5'd24)
        begin
            mi_s     = 4'(mi_sum - 5'd24);
            yr_carry = 2'd2;
        end
        else if (mi_sum >= 5'd12)
        begin
            mi_s     = 4'(mi_sum - 5'd12);
            yr_carry = 2'd1;
        end
        else
        begin
            mi_s     = 4'(mi_sum);
            yr_carry = 2'd0;
        end
        yr_s = 16'(base_year) + 16'(add_years) + 16'(yr_carry);

        s1_next        = '0;
        s1_next.days   = days_s;
        s1_next.mi     = mi_s;
        s1_next.yr     = yr_s;
        s1_next.minute = minute_s;
        s1_next.hour   = hour_s;
    end

    // year modulo 400 by restoring subtraction
    always_comb
    begin
        rem = s1_reg.yr;
        for (int k = 6; k >= 0; k--)
        begin
            if (rem >= (dtda_pkg::CYCLE_LEN << k))
            begin
                rem = rem - (dtda_pkg::CYCLE_LEN << k);
            end
        end
        s2_next      = s1_reg;
        s2_next.y400 = rem[8:0];
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

endmodule

// ===== design/dtda_cell.sv =====
module dtda_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  dtda_pkg::cell_data_t in_data,
    output logic                 out_valid,
    output dtda_pkg::cell_data_t out_data
);

    dtda_pkg::cell_data_t data_reg, data_next;
    logic                 valid_reg;
    logic [4:0]           len;

    // remove one month if the day count runs past it
    always_comb
    begin
        len       = dtda_pkg::month_days(in_data.mi, dtda_pkg::is_leap(in_data.y400));
        data_next = in_data;
        if (in_data.days > 10'(len))
        begin
            data_next.days = in_data.days - 10'(len);
            if (in_data.mi == dtda_pkg::LAST_MI)
            begin
                data_next.mi   = '0;
                data_next.yr   = in_data.yr + 16'd1;
                data_next.y400 = (in_data.y400 == dtda_pkg::LAST_Y400) ? '0
                                                                      : in_data.y400 + 9'd1;
            end
            else
            begin
                data_next.mi = in_data.mi + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/date_time_duration_adder.sv =====
// Date and time plus duration adder.
// Input channel (in_valid/in_ready) carries a base date and time and a
// duration; output channel (out_valid/out_ready) returns the normalized sum
// with the year saturated at 9999 and year_overflow set when it was clipped.
// One result per input transfer, in order.
// From input transfer to out_valid an item passes two front stages, the
// NCELLS month-reduction cells, set by MAX_ADD_DAYS (14 cells at the
// default of 366), and an output register. Throughput is one item per
// cycle while the receiver does not stall: the front stages fold minutes,
// hours and months and reduce the year modulo 400, each cell of the chain
// strips at most one month, and the output register applies the year saturation.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// until the output register is taken; nothing is dropped.
// Reset clears all valid flags; the block comes out of reset empty and ready.
module date_time_duration_adder #(
    parameter int MAX_ADD_DAYS = 366
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [13:0] base_year,
    input  logic [3:0]  base_month,
    input  logic [4:0]  base_day,
    input  logic [4:0]  base_hour,
    input  logic [5:0]  base_minute,
    input  logic [13:0] add_years,
    input  logic [3:0]  add_months,
    input  logic [8:0]  add_days,
    input  logic [4:0]  add_hours,
    input  logic [5:0]  add_minutes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] sum_year,
    output logic [3:0]  sum_month,
    output logic [4:0]  sum_day,
    output logic [4:0]  sum_hour,
    output logic [5:0]  sum_minute,
    output logic        year_overflow
);

    localparam int ADD_CLAMP = (MAX_ADD_DAYS > 511) ? 511 : MAX_ADD_DAYS;
    localparam int DAYS_MAX  = 31 + ADD_CLAMP + 2;
    localparam int NCELLS    = (DAYS_MAX - 28 + 27) / 28;

    logic                 advance;
    logic                 chain_valid [NCELLS+1];
    dtda_pkg::cell_data_t chain_data  [NCELLS+1];
    dtda_pkg::cell_data_t last;

    logic        out_valid_reg;
    logic [13:0] sum_year_reg,   sum_year_next;
    logic [3:0]  sum_month_reg,  sum_month_next;
    logic [4:0]  sum_day_reg,    sum_day_next;
    logic [4:0]  sum_hour_reg,   sum_hour_next;
    logic [5:0]  sum_minute_reg, sum_minute_next;
    logic        ovf_reg,        ovf_next;

    // pipeline moves whenever the output register is free or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    dtda_prep #(
        .MAX_ADD_DAYS (MAX_ADD_DAYS)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_valid),
        .base_year   (base_year),
        .base_month  (base_month),
        .base_day    (base_day),
        .base_hour   (base_hour),
        .base_minute (base_minute),
        .add_years   (add_years),
        .add_months  (add_months),
        .add_days    (add_days),
        .add_hours   (add_hours),
        .add_minutes (add_minutes),
        .out_valid   (chain_valid[0]),
        .out_data    (chain_data[0])
    );

    // month-reduction chain
    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        dtda_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // year saturation into the output register
    always_comb
    begin
        last            = chain_data[NCELLS];
        ovf_next        = last.yr > dtda_pkg::YEAR_MAX;
        sum_year_next   = ovf_next ? dtda_pkg::YEAR_MAX[13:0] : last.yr[13:0];
        sum_month_next  = last.mi + 4'd1;
        sum_day_next    = last.days[4:0];
        sum_hour_next   = last.hour;
        sum_minute_next = last.minute;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_year_reg   <= sum_year_next;
            sum_month_reg  <= sum_month_next;
            sum_day_reg    <= sum_day_next;
            sum_hour_reg   <= sum_hour_next;
            sum_minute_reg <= sum_minute_next;
            ovf_reg        <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[NCELLS];
        end
    end

    assign out_valid     = out_valid_reg;
    assign sum_year      = sum_year_reg;
    assign sum_month     = sum_month_reg;
    assign sum_day       = sum_day_reg;
    assign sum_hour      = sum_hour_reg;
    assign sum_minute    = sum_minute_reg;
    assign year_overflow = ovf_reg;

endmodule

// ===== design/dtda_checker.sv =====
`include "date_time_duration_adder_defines.svh"

module dtda_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [13:0] sum_year,
    input logic [3:0]  sum_month,
    input logic [4:0]  sum_day,
    input logic [4:0]  sum_hour,
    input logic [5:0]  sum_minute,
    input logic        year_overflow
);

    // a stalled result stays offered
    `DTDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

    // a normalized month
    `DTDA_ASSERT_SAME(a_month, out_valid, sum_month != 4'd0 && sum_month <= 4'd12, "bad month")

    // a nonzero day
    `DTDA_ASSERT_SAME(a_day, out_valid, sum_day != 5'd0, "day is zero")

    // time of day is normalized
    `DTDA_ASSERT_SAME(a_time, out_valid, sum_minute < 6'd60 && sum_hour < 5'd24, "bad time")

    // an overflowed year reads as the saturation value
    `DTDA_ASSERT_SAME(a_sat, out_valid && year_overflow, sum_year == 14'd9999, "not saturated")

endmodule

bind date_time_duration_adder dtda_checker u_dtda_checker (.*);
